// ===== hdl/hsv2rgb_pkg.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Shared widths, sector codes, stage payload types and small arithmetic
// helpers for the HSV to RGB pixel pipeline.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

   // Hue is a fraction of a full turn: hue / 2^HUE_FRACTION_BITS
   localparam int HUE_FRACTION_BITS = 16;

   localparam int HUE_W  = 16;
   localparam int CODE_W = 8;
   localparam logic [CODE_W-1:0] FULL_CODE = 8'hFF;

   // hue*6 needs three more bits than the hue
   localparam int SCALED_W  = HUE_W + 3;
   // bits above the fraction that carry the sector (at least one)
   localparam int SEC_SRC_W = (SCALED_W > HUE_FRACTION_BITS) ?
                              (SCALED_W - HUE_FRACTION_BITS) : 1;
   localparam int EXT_W     = HUE_FRACTION_BITS + SEC_SRC_W;

   localparam int FRAC_W  = HUE_FRACTION_BITS;
   // 255*F fits in FRAC_W+8 bits
   localparam int NUM_W   = FRAC_W + CODE_W;
   localparam int PROD_W  = NUM_W + CODE_W;
   localparam int QUOT_IN_W = 2 * CODE_W;

   localparam logic [FRAC_W:0]  ONE_TURN   = {1'b1, {FRAC_W{1'b0}}};
   localparam logic [NUM_W-1:0] FULL_SCALE = {FULL_CODE, {FRAC_W{1'b0}}};

   // Hue sectors, one per sixth of a turn
   typedef enum logic [2:0] {
      SEC_RED_YEL = 3'd0,
      SEC_YEL_GRN = 3'd1,
      SEC_GRN_CYN = 3'd2,
      SEC_CYN_BLU = 3'd3,
      SEC_BLU_MAG = 3'd4,
      SEC_MAG_RED = 3'd5
   } sector_type;

   // After sector split
   typedef struct packed {
      sector_type          sector;
      logic [FRAC_W-1:0]   frac;
      logic [CODE_W-1:0]   sat;
      logic [CODE_W-1:0]   val;
   } split_type;

   // After weight computation
   typedef struct packed {
      sector_type          sector;
      logic [NUM_W-1:0]    num_q;
      logic [NUM_W-1:0]    num_t;
      logic [CODE_W-1:0]   num_p;
      logic [CODE_W-1:0]   val;
   } weight_type;

   // After scaling by brightness
   typedef struct packed {
      sector_type            sector;
      logic [PROD_W-1:0]     prod_q;
      logic [PROD_W-1:0]     prod_t;
      logic [QUOT_IN_W-1:0]  prod_p;
      logic [CODE_W-1:0]     val;
   } scaled_type;

   // Remainder modulo six, one bit per step from the top
   function automatic sector_type mod6(input logic [SEC_SRC_W-1:0] x);
      logic [3:0] acc;
      logic [2:0] rem;
      rem = 3'd0;
      acc = 4'd0;
      for (int i = SEC_SRC_W - 1; i >= 0; i--) begin
         acc = {rem, x[i]};
         if (acc >= 4'd6) begin
            acc = acc - 4'd6;
         end
         rem = acc[2:0];
      end
      return sector_type'(rem);
   endfunction

   // Exact floor(y/255) for any y up to 255*255: (y + (y >> 8) + 1) >> 8
   function automatic logic [CODE_W-1:0] div255(input logic [QUOT_IN_W-1:0] y);
      logic [QUOT_IN_W:0] sum;
      sum = {1'b0, y} + (QUOT_IN_W+1)'(y[QUOT_IN_W-1:CODE_W]) + (QUOT_IN_W+1)'(1);
      return sum[QUOT_IN_W-1:CODE_W];
   endfunction

endpackage

// ===== hdl/hsv2rgb_if.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB converter channels
// Valid/ready channels for HSV items in and RGB items out.
// ----------------------------------------------------------------------------
interface hsv2rgb_req_if;
   import hsv2rgb_pkg::*;

   logic                valid;
   logic                ready;
   logic [HUE_W-1:0]    hue;
   logic [CODE_W-1:0]   saturation;
   logic [CODE_W-1:0]   brightness;

   modport source (output valid, output hue, output saturation, output brightness,
                   input ready);
   modport sink   (input valid, input hue, input saturation, input brightness,
                   output ready);
endinterface

interface hsv2rgb_rsp_if;
   import hsv2rgb_pkg::*;

   logic                valid;
   logic                ready;
   logic [CODE_W-1:0]   red;
   logic [CODE_W-1:0]   green;
   logic [CODE_W-1:0]   blue;

   modport source (output valid, output red, output green, output blue,
                   input ready);
   modport sink   (input valid, input red, input green, input blue,
                   output ready);
endinterface

// ===== hdl/hsv2rgb_sector_split.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB sector split stage
// Forms hue*6 and splits it into the sector (modulo six) and the fraction.
// ----------------------------------------------------------------------------
module hsv2rgb_sector_split (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        up_valid,
   output logic                        up_ready,
   input  logic [hsv2rgb_pkg::HUE_W-1:0]  hue,
   input  logic [hsv2rgb_pkg::CODE_W-1:0] sat,
   input  logic [hsv2rgb_pkg::CODE_W-1:0] val,
   output logic                        dn_valid,
   input  logic                        dn_ready,
   output hsv2rgb_pkg::split_type      dn_data
);
   import hsv2rgb_pkg::*;

   logic                 valid_ff;
   logic                 valid_in;
   split_type            data_ff;
   split_type            data_in;
   logic [SCALED_W-1:0]  scaled;
   logic [EXT_W-1:0]     scaled_ext;

   // hue*6 as two shifted adds, then split at the fraction point
   always_comb begin
      scaled     = (SCALED_W'(hue) << 2) + (SCALED_W'(hue) << 1);
      scaled_ext = EXT_W'(scaled);
      data_in.sector = mod6(scaled_ext[EXT_W-1:FRAC_W]);
      data_in.frac   = scaled_ext[FRAC_W-1:0];
      data_in.sat    = sat;
      data_in.val    = val;
   end

   // Advance when empty or when the next stage takes the item
   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

// ===== hdl/hsv2rgb_weights.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB weight stage
// Computes the numerators 255*F - s*f, 255*F - s*(F-f) and 255 - s.
// ----------------------------------------------------------------------------
module hsv2rgb_weights (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     up_valid,
   output logic                     up_ready,
   input  hsv2rgb_pkg::split_type   up_data,
   output logic                     dn_valid,
   input  logic                     dn_ready,
   output hsv2rgb_pkg::weight_type  dn_data
);
   import hsv2rgb_pkg::*;

   logic               valid_ff;
   logic               valid_in;
   weight_type         data_ff;
   weight_type         data_in;
   logic [FRAC_W:0]    frac_comp;
   logic [NUM_W-1:0]   sat_frac;
   logic [NUM_W-1:0]   sat_comp;

   // One small multiply for each of the q and t numerators, then subtract from full scale
   always_comb begin
      frac_comp = ONE_TURN - (FRAC_W+1)'(up_data.frac);
      sat_frac  = NUM_W'(up_data.sat) * NUM_W'(up_data.frac);
      sat_comp  = NUM_W'(up_data.sat) * NUM_W'(frac_comp);
      data_in.sector = up_data.sector;
      data_in.num_q  = FULL_SCALE - sat_frac;
      data_in.num_t  = FULL_SCALE - sat_comp;
      data_in.num_p  = FULL_CODE - up_data.sat;
      data_in.val    = up_data.val;
   end

   // Advance when empty or when the next stage takes the item
   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

// ===== hdl/hsv2rgb_scale.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB scale stage
// Multiplies each numerator by the brightness.
// ----------------------------------------------------------------------------
module hsv2rgb_scale (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     up_valid,
   output logic                     up_ready,
   input  hsv2rgb_pkg::weight_type  up_data,
   output logic                     dn_valid,
   input  logic                     dn_ready,
   output hsv2rgb_pkg::scaled_type  dn_data
);
   import hsv2rgb_pkg::*;

   logic        valid_ff;
   logic        valid_in;
   scaled_type  data_ff;
   scaled_type  data_in;

   // Scale the three numerators by v
   always_comb begin
      data_in.sector = up_data.sector;
      data_in.prod_q = PROD_W'(up_data.val) * PROD_W'(up_data.num_q);
      data_in.prod_t = PROD_W'(up_data.val) * PROD_W'(up_data.num_t);
      data_in.prod_p = QUOT_IN_W'(up_data.val) * QUOT_IN_W'(up_data.num_p);
      data_in.val    = up_data.val;
   end

   // Advance when empty or when the next stage takes the item
   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

// ===== hdl/hsv2rgb_route.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB divide and route stage
// Divides the q and t products by 255*F and the p product by 255, routes v/p/q/t
// by sector and holds the result item in the output register.
// ----------------------------------------------------------------------------
module hsv2rgb_route (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        up_valid,
   output logic                        up_ready,
   input  hsv2rgb_pkg::scaled_type     up_data,
   output logic                        dn_valid,
   input  logic                        dn_ready,
   output logic [hsv2rgb_pkg::CODE_W-1:0] red,
   output logic [hsv2rgb_pkg::CODE_W-1:0] green,
   output logic [hsv2rgb_pkg::CODE_W-1:0] blue
);
   import hsv2rgb_pkg::*;

   logic                valid_ff;
   logic                valid_in;
   logic [CODE_W-1:0]   red_ff;
   logic [CODE_W-1:0]   green_ff;
   logic [CODE_W-1:0]   blue_ff;
   logic [CODE_W-1:0]   red_in;
   logic [CODE_W-1:0]   green_in;
   logic [CODE_W-1:0]   blue_in;
   logic [CODE_W-1:0]   p_val;
   logic [CODE_W-1:0]   q_val;
   logic [CODE_W-1:0]   t_val;
   logic [CODE_W-1:0]   v_val;

   // Drop the fraction bits of q and t, then divide all three by 255
   always_comb begin
      p_val = div255(up_data.prod_p);
      q_val = div255(up_data.prod_q[PROD_W-1:FRAC_W]);
      t_val = div255(up_data.prod_t[PROD_W-1:FRAC_W]);
      v_val = up_data.val;
   end

   // Route by sector
   always_comb begin
      case (up_data.sector)
         SEC_RED_YEL: begin
            red_in = v_val; green_in = t_val; blue_in = p_val;
         end
         SEC_YEL_GRN: begin
            red_in = q_val; green_in = v_val; blue_in = p_val;
         end
         SEC_GRN_CYN: begin
            red_in = p_val; green_in = v_val; blue_in = t_val;
         end
         SEC_CYN_BLU: begin
            red_in = p_val; green_in = q_val; blue_in = v_val;
         end
         SEC_BLU_MAG: begin
            red_in = t_val; green_in = p_val; blue_in = v_val;
         end
         default: begin
            red_in = v_val; green_in = p_val; blue_in = q_val;
         end
      endcase
   end

   // Advance when empty or when the consumer takes the item
   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign dn_valid = valid_ff;
   assign red      = red_ff;
   assign green    = green_ff;
   assign blue     = blue_ff;

endmodule

// ===== hdl/hsv_to_rgb_converter_unit.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB converter unit
// Converts one HSV pixel per item to 8-bit RGB through a four-stage pipeline.
//
//   channel   direction   payload                         handshake
//   req_if    in          hue[15:0] saturation brightness  valid/ready
//   rsp_if    out         red green blue                   valid/ready
//
// Takes one item per cycle unless the output stalls; each item passes in order
// through sector split, weights, scale by brightness, divide and route.
// Reset clears the stage valid bits; the data registers are not reset.
// Each stage holds its item while the next one is full and stalled; ready
// runs back through the stages, so a full pipeline still takes a new item
// in the cycle its output item is taken.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_unit (
   input  logic            clock,
   input  logic            reset,
   hsv2rgb_req_if.sink     req_if,
   hsv2rgb_rsp_if.source   rsp_if
);
   import hsv2rgb_pkg::*;

   logic        split_valid;
   logic        split_ready;
   split_type   split_data;
   logic        weight_valid;
   logic        weight_ready;
   weight_type  weight_data;
   logic        scale_valid;
   logic        scale_ready;
   scaled_type  scale_data;

   // Stage 1: sector and fraction
   hsv2rgb_sector_split u_split (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_if.valid),
      .up_ready (req_if.ready),
      .hue      (req_if.hue),
      .sat      (req_if.saturation),
      .val      (req_if.brightness),
      .dn_valid (split_valid),
      .dn_ready (split_ready),
      .dn_data  (split_data)
   );

   // Stage 2: numerators
   hsv2rgb_weights u_weights (
      .clock    (clock),
      .reset    (reset),
      .up_valid (split_valid),
      .up_ready (split_ready),
      .up_data  (split_data),
      .dn_valid (weight_valid),
      .dn_ready (weight_ready),
      .dn_data  (weight_data)
   );

   // Stage 3: scale by brightness
   hsv2rgb_scale u_scale (
      .clock    (clock),
      .reset    (reset),
      .up_valid (weight_valid),
      .up_ready (weight_ready),
      .up_data  (weight_data),
      .dn_valid (scale_valid),
      .dn_ready (scale_ready),
      .dn_data  (scale_data)
   );

   // Stage 4: divide, route and output register
   hsv2rgb_route u_route (
      .clock    (clock),
      .reset    (reset),
      .up_valid (scale_valid),
      .up_ready (scale_ready),
      .up_data  (scale_data),
      .dn_valid (rsp_if.valid),
      .dn_ready (rsp_if.ready),
      .red      (rsp_if.red),
      .green    (rsp_if.green),
      .blue     (rsp_if.blue)
   );

   // Reset empties the pipeline
   assert property (@(posedge clock) reset |=> !rsp_if.valid && !split_valid)
      else $error("pipeline not empty after reset");

   // Input only stalls when every stage is full and the output is stalled
   assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> (split_valid && weight_valid && scale_valid &&
                         rsp_if.valid && !rsp_if.ready))
      else $error("input stalled with room in the pipeline");

   // An accepted item lands in the first stage
   assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> split_valid)
      else $error("accepted item lost at the first stage");

   // A stalled output keeps itself and the stage behind it full
   assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.ready && scale_valid) |=> rsp_if.valid && scale_valid)
      else $error("stalled item dropped");

endmodule
